@@ hdl/tdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tdt_pkg
// Shared constants, codes and types for the tag strength table.
// ---------------------------------------------------------------------------
package tdt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int ID_W    = 96;
  localparam int HI_W    = 32;
  localparam int LO_W    = 64;
  localparam int DBM_W   = 9;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;

  localparam logic [DBM_W-1:0] DBM_FLOOR = 9'h101;  // -255

  // request codes
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REWIND = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ     = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STAT_W-1:0] ST_PAST_END = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } state_t;

  // write port of the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [ID_W-1:0]  id;
    logic [DBM_W-1:0] dbm;
  } wr_t;

  // registered read data, already resolved against the valid bits
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DBM_W-1:0] dbm;
  } rd_t;

endpackage
`default_nettype wire

@@ hdl/tdt_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tdt_store
// Entry store: tag IDs and best strengths, one write and one registered read
// per cycle. Per-entry valid bits make a never-written entry read as empty
// with the floor strength.
// ---------------------------------------------------------------------------
module tdt_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [tdt_pkg::IDX_W-1:0] rd_addr,
  output tdt_pkg::rd_t                   rd,
  input  wire tdt_pkg::wr_t              wr
);

  logic [tdt_pkg::ID_W-1:0]    id_mem  [tdt_pkg::ENTRIES];
  logic [tdt_pkg::DBM_W-1:0]   dbm_mem [tdt_pkg::ENTRIES];
  logic [tdt_pkg::ENTRIES-1:0] valid;

  logic [tdt_pkg::ID_W-1:0]  id_q;
  logic [tdt_pkg::DBM_W-1:0] dbm_q;
  logic                      vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_mem[wr.addr]  <= wr.id;
      dbm_mem[wr.addr] <= wr.dbm;
    end
    id_q  <= id_mem[rd_addr];
    dbm_q <= dbm_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      vld_q <= valid[rd_addr];
    end
  end

  assign rd.id  = vld_q ? id_q : '0;
  assign rd.dbm = vld_q ? dbm_q : tdt_pkg::DBM_FLOOR;

endmodule
`default_nettype wire

@@ hdl/tag_rssi_dedup_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tag_rssi_dedup_table
// Table of seen tag IDs with best signal strength; reports are matched or
// inserted by a linear scan, reads drain the table through a read pointer.
// ---------------------------------------------------------------------------
//  channel   handshake          ports
//  request   start & !busy      req_type, epc_upper, epc_lower, signal_dbm
//  result    done (one cycle)   status, slot, out_epc_upper, out_epc_lower,
//                               best_dbm
//
// Report: scan reads one slot per cycle from the entry store through its
//   single read port.
// Read: one store read, then write-back. Read past end: result
//   the cycle after the transaction; rewind: no result, busy never rises.
// Reset clears control and the store's valid bits.
// The receiver cannot stall; each result is shown for one cycle only.
// ---------------------------------------------------------------------------
module tag_rssi_dedup_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tdt_pkg::REQ_W-1:0]         req_type,
  input  wire logic [tdt_pkg::HI_W-1:0]          epc_upper,
  input  wire logic [tdt_pkg::LO_W-1:0]          epc_lower,
  input  wire logic signed [tdt_pkg::DBM_W-1:0]  signal_dbm,
  output logic                                   done,
  output logic [tdt_pkg::STAT_W-1:0]             status,
  output logic [tdt_pkg::SLOT_W-1:0]             slot,
  output logic [tdt_pkg::HI_W-1:0]               out_epc_upper,
  output logic [tdt_pkg::LO_W-1:0]               out_epc_lower,
  output logic signed [tdt_pkg::DBM_W-1:0]       best_dbm
);

  localparam logic [tdt_pkg::PTR_W-1:0] PTR_END  = tdt_pkg::PTR_W'(tdt_pkg::ENTRIES);
  localparam logic [tdt_pkg::IDX_W-1:0] IDX_LAST = tdt_pkg::IDX_W'(tdt_pkg::ENTRIES - 1);

  tdt_pkg::state_t state, state_next;

  logic [tdt_pkg::PTR_W-1:0] scan_idx;
  logic [tdt_pkg::PTR_W-1:0] ptr;
  logic                      live_q;
  logic [tdt_pkg::IDX_W-1:0] data_idx;

  logic [tdt_pkg::REQ_W-1:0] req_q;
  logic [tdt_pkg::ID_W-1:0]  id_q;
  logic [tdt_pkg::DBM_W-1:0] dbm_q;

  tdt_pkg::rd_t rd;
  tdt_pkg::wr_t wr;

  logic accept;
  logic hit_match, hit_empty, last;
  logic [tdt_pkg::DBM_W-1:0] raised;

  logic                       emit;
  logic [tdt_pkg::STAT_W-1:0] e_status;
  logic [tdt_pkg::SLOT_W-1:0] e_slot;
  logic [tdt_pkg::ID_W-1:0]   e_id;
  logic [tdt_pkg::DBM_W-1:0]  e_dbm;

  tdt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (scan_idx[tdt_pkg::IDX_W-1:0]),
    .rd      (rd),
    .wr      (wr)
  );

  assign busy   = (state != tdt_pkg::S_IDLE);
  assign accept = start && !busy;

  assign hit_match = live_q && (rd.id == id_q);
  assign hit_empty = live_q && (rd.id == '0);
  assign last      = live_q && (data_idx == IDX_LAST);
  assign raised    = ($signed(dbm_q) > $signed(rd.dbm)) ? dbm_q : rd.dbm;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdt_pkg::S_IDLE: begin
        if (accept && req_type == tdt_pkg::REQ_REPORT) begin
          state_next = tdt_pkg::S_SCAN;
        end else if (accept && req_type == tdt_pkg::REQ_READ && ptr != PTR_END) begin
          state_next = tdt_pkg::S_READ;
        end
      end
      tdt_pkg::S_SCAN: begin
        if (hit_match || hit_empty || last) begin
          state_next = tdt_pkg::S_IDLE;
        end
      end
      tdt_pkg::S_READ: begin
        if (live_q) begin
          state_next = tdt_pkg::S_IDLE;
        end
      end
      default: state_next = tdt_pkg::S_IDLE;
    endcase
  end

  // result and store write
  always_comb begin
    emit     = 1'b0;
    e_status = tdt_pkg::ST_UPDATED;
    e_slot   = tdt_pkg::SLOT_W'(data_idx);
    e_id     = '0;
    e_dbm    = rd.dbm;
    wr       = '0;
    wr.addr  = data_idx;
    unique case (state)
      tdt_pkg::S_IDLE: begin
        if (accept && req_type == tdt_pkg::REQ_READ && ptr == PTR_END) begin
          emit     = 1'b1;
          e_status = tdt_pkg::ST_PAST_END;
          e_slot   = '0;
          e_dbm    = '0;
        end
      end
      tdt_pkg::S_SCAN: begin
        // an ID match takes priority over an empty slot (all-zero report)
        priority if (hit_match) begin
          emit     = 1'b1;
          e_status = tdt_pkg::ST_UPDATED;
          e_dbm    = raised;
          wr.en    = 1'b1;
          wr.id    = id_q;
          wr.dbm   = raised;
        end else if (hit_empty) begin
          emit     = 1'b1;
          e_status = tdt_pkg::ST_INSERTED;
          e_dbm    = dbm_q;
          wr.en    = 1'b1;
          wr.id    = id_q;
          wr.dbm   = dbm_q;
        end else if (last) begin
          emit     = 1'b1;
          e_status = tdt_pkg::ST_FULL;
          e_slot   = '0;
          e_dbm    = tdt_pkg::DBM_FLOOR;
        end else begin
        end
      end
      tdt_pkg::S_READ: begin
        if (live_q) begin
          emit     = 1'b1;
          e_status = (rd.id == '0) ? tdt_pkg::ST_EMPTY : tdt_pkg::ST_READ;
          e_id     = rd.id;
          wr.en    = 1'b1;
          wr.id    = '0;      // clear the ID, keep the strength
          wr.dbm   = rd.dbm;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tdt_pkg::S_IDLE;
      ptr    <= '0;
      live_q <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      live_q <= (state == tdt_pkg::S_SCAN || state == tdt_pkg::S_READ) &&
                (scan_idx < PTR_END);
      done   <= emit;
      if (accept && req_type == tdt_pkg::REQ_REWIND) begin
        ptr <= '0;
      end else if (state == tdt_pkg::S_READ && live_q) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // scan address, request payload and result payload
  always_ff @(posedge clk) begin
    data_idx <= scan_idx[tdt_pkg::IDX_W-1:0];
    if (accept) begin
      req_q    <= req_type;
      id_q     <= {epc_upper, epc_lower};
      dbm_q    <= signal_dbm;
      scan_idx <= (req_type == tdt_pkg::REQ_READ) ? ptr : '0;
    end else if (state == tdt_pkg::S_SCAN && scan_idx < PTR_END) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (emit) begin
      status        <= e_status;
      slot          <= e_slot;
      out_epc_upper <= e_id[tdt_pkg::ID_W-1:tdt_pkg::LO_W];
      out_epc_lower <= e_id[tdt_pkg::LO_W-1:0];
      best_dbm      <= e_dbm;
    end
  end

  // ---- assertions ----
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_END)
    else $error("read pointer beyond table end");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == tdt_pkg::S_SCAN |-> scan_idx <= PTR_END)
    else $error("scan index beyond table end");

  a_done_on_exit: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && done |-> $past(busy) || $past(start))
    else $error("result without a transaction");

  a_scan_req: assert property (@(posedge clk) disable iff (rst)
    state == tdt_pkg::S_SCAN |-> req_q == tdt_pkg::REQ_REPORT)
    else $error("scan running for a request other than a report");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the tag strength table. Requests are queued up
// front and sent by a clocked driver with random gaps. Each accepted request
// is applied to a local copy of the table, which queues the result the block
// should give. A clocked monitor checks every done strobe against that queue.
// ---------------------------------------------------------------------------
module testbench;
  import tdt_pkg::*;

  // request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int N_ITEMS   = 1750;
  localparam int TAIL_CYC  = 40;

  typedef struct {
    logic [REQ_W-1:0]        kind;
    logic [HI_W-1:0]         hi;
    logic [LO_W-1:0]         lo;
    logic signed [DBM_W-1:0] dbm;
  } tag_req_t;

  typedef struct {
    logic [STAT_W-1:0]       st;
    logic [SLOT_W-1:0]       slot;
    logic [HI_W-1:0]         hi;
    logic [LO_W-1:0]         lo;
    logic signed [DBM_W-1:0] dbm;
  } tag_res_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [REQ_W-1:0]        req_type = '0;
  logic [HI_W-1:0]         epc_upper = '0;
  logic [LO_W-1:0]         epc_lower = '0;
  logic signed [DBM_W-1:0] signal_dbm = '0;
  logic                    busy;
  logic                    done;
  logic [STAT_W-1:0]       status;
  logic [SLOT_W-1:0]       slot;
  logic [HI_W-1:0]         out_epc_upper;
  logic [LO_W-1:0]         out_epc_lower;
  logic signed [DBM_W-1:0] best_dbm;

  tag_rssi_dedup_table dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .epc_upper     (epc_upper),
    .epc_lower     (epc_lower),
    .signal_dbm    (signal_dbm),
    .done          (done),
    .status        (status),
    .slot          (slot),
    .out_epc_upper (out_epc_upper),
    .out_epc_lower (out_epc_lower),
    .best_dbm      (best_dbm)
  );

  always #2 clk = ~clk;

  // local copy of the table
  logic [ID_W-1:0]         tbl_id  [ENTRIES];
  logic signed [DBM_W-1:0] tbl_dbm [ENTRIES];
  int                      tbl_rptr;

  tag_req_t req_queue[$];
  tag_res_t due_results[$];
  tag_req_t drv_req;
  int       n_queued;
  int       n_items;
  int       n_accepted;
  int       n_bad;
  int       gap_left;
  bit       calm;

  // Apply one accepted transaction to the table copy and queue its result.
  function void apply_to_table(input tag_req_t r);
    tag_res_t        res;
    logic [ID_W-1:0] id;
    bit              hit;
    id  = {r.hi, r.lo};
    hit = 1'b0;
    case (r.kind)
      REQ_REPORT: begin
        res = '{ST_FULL, '0, '0, '0, DBM_FLOOR};
        for (int k = 0; k < ENTRIES && !hit; k++) begin
          // match is tested before empty, so an all-zero ID hits the first hole
          if (tbl_id[k] == id) begin
            if (r.dbm > tbl_dbm[k]) tbl_dbm[k] = r.dbm;
            res = '{ST_UPDATED, SLOT_W'(k), '0, '0, tbl_dbm[k]};
            hit = 1'b1;
          end else if (tbl_id[k] == '0) begin
            tbl_id[k]  = id;
            tbl_dbm[k] = r.dbm;
            res = '{ST_INSERTED, SLOT_W'(k), '0, '0, tbl_dbm[k]};
            hit = 1'b1;
          end
        end
        due_results.push_back(res);
      end
      REQ_READ: begin
        if (tbl_rptr >= ENTRIES) begin
          res = '{ST_PAST_END, '0, '0, '0, '0};
        end else begin
          if (tbl_id[tbl_rptr] == '0)
            res = '{ST_EMPTY, SLOT_W'(tbl_rptr), '0, '0, tbl_dbm[tbl_rptr]};
          else
            res = '{ST_READ, SLOT_W'(tbl_rptr), tbl_id[tbl_rptr][ID_W-1:LO_W],
                    tbl_id[tbl_rptr][LO_W-1:0], tbl_dbm[tbl_rptr]};
          // strength is kept, only the ID is cleared
          tbl_id[tbl_rptr] = '0;
          tbl_rptr++;
        end
        due_results.push_back(res);
      end
      REQ_REWIND: begin
        tbl_rptr = 0;
      end
      default: ;
    endcase
  endfunction

  function void add_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                        input logic signed [DBM_W-1:0] dbm);
    tag_req_t r;
    r = '{kind, id[ID_W-1:LO_W], id[LO_W-1:0], dbm};
    req_queue.push_back(r);
    n_queued++;
    if (kind != REQ_UNUSED) n_items++;
  endfunction

  function logic [ID_W-1:0] rand_id();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  function logic signed [DBM_W-1:0] rand_dbm();
    int r;
    r = $urandom_range(7, 0);
    if (r == 0) return DBM_FLOOR;
    if (r == 1) return '0;
    return DBM_W'(-int'($urandom_range(255, 0)));
  endfunction

  function void flag_result(input string why, input tag_res_t want, input tag_res_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t: %s", $time, why);
      $display("  expected st=%0d slot=%0d id=%h_%h dbm=%0d",
               want.st, want.slot, want.hi, want.lo, want.dbm);
      $display("  actual   st=%0d slot=%0d id=%h_%h dbm=%0d",
               got.st, got.slot, got.hi, got.lo, got.dbm);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    bit line_free;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      line_free = !start;
      if (start && !busy) begin
        apply_to_table(drv_req);
        n_accepted++;
        line_free = 1'b1;
        if ($urandom_range(63, 0) == 0) calm = !calm;
        if (calm) begin
          gap_left = 0;
        end else begin
          case ($urandom_range(19, 0))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap_left = 0;
            11, 12, 13, 14, 15, 16:            gap_left = $urandom_range(3, 1);
            17, 18:                            gap_left = $urandom_range(10, 4);
            default:                           gap_left = $urandom_range(40, 20);
          endcase
        end
      end
      if (line_free) begin
        if (gap_left > 0 || req_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          drv_req = req_queue.pop_front();
          start      <= 1'b1;
          req_type   <= drv_req.kind;
          epc_upper  <= drv_req.hi;
          epc_lower  <= drv_req.lo;
          signal_dbm <= drv_req.dbm;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tag_res_t got;
    tag_res_t want;
    if (!rst && done) begin
      got = '{status, slot, out_epc_upper, out_epc_lower, best_dbm};
      if (due_results.size() == 0) begin
        want = '{'0, '0, '0, '0, '0};
        flag_result("result with no transaction pending", want, got);
      end else begin
        want = due_results.pop_front();
        if (got.st !== want.st || got.slot !== want.slot || got.hi !== want.hi ||
            got.lo !== want.lo || got.dbm !== want.dbm)
          flag_result("result mismatch", want, got);
      end
    end
  end

  initial begin
    int              pick;
    int              n;
    int              r;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] pool[$];

    for (int k = 0; k < ENTRIES; k++) begin
      tbl_id[k]  = '0;
      tbl_dbm[k] = DBM_FLOOR;
    end
    tbl_rptr = 0;

    // directed: empty reads, all-zero IDs, extremes, partial-zero IDs,
    // strength kept across a read, ignored request code
    add_req(REQ_READ,    '0, '0);
    add_req(REQ_REWIND,  '1, '1);
    add_req(REQ_REPORT,  '0, -9'sd100);
    add_req(REQ_REPORT,  '0, -9'sd200);
    add_req(REQ_REPORT,  '1, '0);
    add_req(REQ_REPORT,  '1, DBM_FLOOR);
    add_req(REQ_REPORT,  {32'h1, 64'h0}, DBM_FLOOR);
    add_req(REQ_REPORT,  {32'h0, 64'h1}, -9'sd1);
    add_req(REQ_REPORT,  {32'h1, 64'h0}, -9'sd3);
    add_req(REQ_REPORT,  '0, '0);
    add_req(REQ_UNUSED,  '1, -9'sd1);
    add_req(REQ_READ,    '1, '1);
    add_req(REQ_READ,    '0, '0);
    add_req(REQ_READ,    '1, '1);
    add_req(REQ_READ,    '0, '0);
    add_req(REQ_REWIND,  '0, '0);
    add_req(REQ_READ,    '0, '0);
    add_req(REQ_REPORT,  {32'hdeadbeef, 64'h0123456789abcdef}, -9'sd128);
    add_req(REQ_READ,    '0, '0);

    // random: fill bursts, repeats and near misses, drains, noise
    while (n_items < N_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        n = $urandom_range(22, 8);
        repeat (n) begin
          if (pool.size() > 0 && $urandom_range(3, 0) == 0) begin
            id = pool[$urandom_range(pool.size() - 1, 0)];
          end else begin
            id = rand_id();
            pool.push_back(id);
          end
          add_req(REQ_REPORT, id, rand_dbm());
        end
      end else if (pick < 55) begin
        n = $urandom_range(12, 3);
        repeat (n) begin
          r = $urandom_range(15, 0);
          if (pool.size() == 0 || r == 0) begin
            id = '0;
          end else begin
            id = pool[$urandom_range(pool.size() - 1, 0)];
            if (r < 3) id ^= (96'd1 << $urandom_range(ID_W - 1, 0));
          end
          add_req(REQ_REPORT, id, rand_dbm());
        end
      end else if (pick < 82) begin
        if ($urandom_range(1, 0)) add_req(REQ_REWIND, rand_id(), rand_dbm());
        n = $urandom_range(20, 1);
        repeat (n) add_req(REQ_READ, rand_id(), rand_dbm());
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) add_req(REQ_W'($urandom_range(3, 0)), rand_id(), rand_dbm());
      end
      while (pool.size() > 48) void'(pool.pop_front());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted != n_queued) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (n_bad == 0 && due_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

endmodule
